// ===== sv/vcpu_cache_occupancy_accounting_core_macros.svh =====
// Assertion macros shared by the vcpu cache occupancy accounting RTL.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef VCPU_CACHE_OCCUPANCY_ACCOUNTING_CORE_MACROS_SVH
`define VCPU_CACHE_OCCUPANCY_ACCOUNTING_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define VCOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that a condition never holds.
`define VCOA_NEVER(lbl, expr, msg) `VCOA_ASSERT(lbl, !(expr), msg)
`else
`define VCOA_ASSERT(lbl, prop, msg)
`define VCOA_NEVER(lbl, expr, msg)
`endif
`endif

// ===== sv/vcoa_pkg.sv =====
// Shared types and constants for the vcpu cache occupancy accounting core.
// No dependencies; imported by every module of the block.
`default_nettype none

package vcoa_pkg;

  // Default number of vcpu records.
  localparam int VCPU_COUNT_DEF = 16;

  // Configuration register index, taken from paddr[2].
  localparam logic REG_ENABLE = 1'b0;
  localparam logic REG_LINES  = 1'b1;

  // Store control from the top level.
  typedef struct packed {
    logic rd_en;    // read all stores at the request address
    logic snap_we;  // write the three snapshots
    logic occ_we;   // write the occupancy estimate
  } store_ctl_t;

  // Registered read data of one vcpu record.
  typedef struct packed {
    logic [63:0] lcl;
    logic [63:0] glb;
    logic [63:0] ret;
    logic [63:0] occ;
  } rd_data_t;

  // One finished result.
  typedef struct packed {
    logic [3:0]  vcpu;
    logic [63:0] occupancy;
    logic [63:0] mpki;
    logic        dz;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/vcoa_store.sv =====
// Per-vcpu record stores: snapshots and occupancy estimate, with valid bits.
// Depends on vcoa_pkg and the assertion macro header.
`default_nettype none
`include "vcpu_cache_occupancy_accounting_core_macros.svh"

module vcoa_store import vcoa_pkg::*; #(
  parameter  int VCPU_COUNT = VCPU_COUNT_DEF,
  localparam int IdxW       = (VCPU_COUNT > 1) ? $clog2(VCPU_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  store_ctl_t      ctl_i,
  input  logic [IdxW-1:0] addr_i,
  input  logic [IdxW-1:0] occ_addr_i,
  input  logic [63:0]     lcl_i,
  input  logic [63:0]     glb_i,
  input  logic [63:0]     ret_i,
  input  logic [63:0]     occ_i,
  output rd_data_t        rd_o
);

  logic [63:0] lcl_mem [VCPU_COUNT];
  logic [63:0] glb_mem [VCPU_COUNT];
  logic [63:0] ret_mem [VCPU_COUNT];
  logic [63:0] occ_mem [VCPU_COUNT];

  logic [VCPU_COUNT-1:0] snap_vld_q, snap_vld_d;
  logic [VCPU_COUNT-1:0] occ_vld_q, occ_vld_d;
  logic                  rd_snap_vld_q, rd_occ_vld_q;
  rd_data_t              rd_q;

  always_comb begin
    snap_vld_d = snap_vld_q;
    occ_vld_d  = occ_vld_q;
    if (ctl_i.snap_we) begin
      snap_vld_d[addr_i] = 1'b1;
    end
    if (ctl_i.occ_we) begin
      occ_vld_d[occ_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= '0;
      occ_vld_q  <= '0;
    end else begin
      snap_vld_q <= snap_vld_d;
      occ_vld_q  <= occ_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.snap_we) begin
      lcl_mem[addr_i] <= lcl_i;
      glb_mem[addr_i] <= glb_i;
      ret_mem[addr_i] <= ret_i;
    end
    if (ctl_i.occ_we) begin
      occ_mem[occ_addr_i] <= occ_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_q.lcl      <= lcl_mem[addr_i];
      rd_q.glb      <= glb_mem[addr_i];
      rd_q.ret      <= ret_mem[addr_i];
      rd_q.occ      <= occ_mem[addr_i];
      rd_snap_vld_q <= snap_vld_q[addr_i];
      rd_occ_vld_q  <= occ_vld_q[addr_i];
    end
  end

  // Never-written records read as zero.
  assign rd_o.lcl = rd_snap_vld_q ? rd_q.lcl : 64'd0;
  assign rd_o.glb = rd_snap_vld_q ? rd_q.glb : 64'd0;
  assign rd_o.ret = rd_snap_vld_q ? rd_q.ret : 64'd0;
  assign rd_o.occ = rd_occ_vld_q  ? rd_q.occ : 64'd0;

  `VCOA_NEVER(a_store_one_writer, ctl_i.snap_we && ctl_i.occ_we, "write collision")
  `VCOA_NEVER(a_store_rd_snap, ctl_i.rd_en && ctl_i.snap_we, "read with snapshot write")
  `VCOA_NEVER(a_store_rd_occ, ctl_i.rd_en && ctl_i.occ_we, "read with occupancy write")

endmodule

`default_nettype wire

// ===== sv/vcoa_engine.sv =====
// Sequencer and datapath for end requests around one shared 65-bit adder.
// Depends on vcoa_pkg and the assertion macro header.
`default_nettype none
`include "vcpu_cache_occupancy_accounting_core_macros.svh"

module vcoa_engine import vcoa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [3:0]  vcpu_i,
  input  logic [63:0] lm_i,
  input  logic [63:0] gm_i,
  input  logic [63:0] ir_i,
  input  logic [31:0] line_count_i,
  input  rd_data_t    rd_i,
  input  logic        ack_i,
  output logic        busy_o,
  output logic        done_o,
  output result_t     res_o,
  output logic        occ_we_o,
  output logic [63:0] occ_wdata_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'h001,
    S_DL    = 12'h002,
    S_DG    = 12'h004,
    S_DI    = 12'h008,
    S_SHIFT = 12'h010,
    S_MUL   = 12'h020,
    S_OCC1  = 12'h040,
    S_OCC2  = 12'h080,
    S_K1    = 12'h100,
    S_K2    = 12'h200,
    S_DIV   = 12'h400,
    S_DONE  = 12'h800
  } state_e;

  state_e      state_q, state_d;
  logic [3:0]  vcpu_q, vcpu_d;
  logic [63:0] lm_q, lm_d, gm_q, gm_d, ir_q, ir_d;
  logic [63:0] dl_q, dl_d, di_q, di_d, occ_q, occ_d;
  logic [63:0] acc_q, acc_d;   // product / scaled local delta
  logic [63:0] opa_q, opa_d;   // multiplicand, then remainder
  logic [63:0] opb_q, opb_d;   // global delta / multiplier, then quotient
  logic [31:0] n_q, n_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        dz_q, dz_d;

  logic [64:0] unit_a, unit_b, unit_b_x;
  logic        unit_sub;
  logic [65:0] unit_sum;
  logic [63:0] unit_res;
  logic        unit_ge;
  logic [64:0] rem_shift;

  assign rem_shift = {opa_q, opb_q[63]};

  // Operand select for the shared adder.
  always_comb begin
    unit_a   = '0;
    unit_b   = '0;
    unit_sub = 1'b0;
    unique case (state_q)
      S_DL: begin
        unit_a   = {1'b0, lm_q};
        unit_b   = {1'b0, rd_i.lcl};
        unit_sub = 1'b1;
      end
      S_DG: begin
        unit_a   = {1'b0, gm_q};
        unit_b   = {1'b0, rd_i.glb};
        unit_sub = 1'b1;
      end
      S_DI: begin
        unit_a   = {1'b0, ir_q};
        unit_b   = {1'b0, rd_i.ret};
        unit_sub = 1'b1;
      end
      S_MUL: begin
        unit_a = {1'b0, acc_q};
        unit_b = {1'b0, opa_q};
      end
      S_OCC1: begin
        unit_a = {1'b0, rd_i.occ};
        unit_b = {1'b0, dl_q};
      end
      S_OCC2: begin
        unit_a   = {1'b0, occ_q};
        unit_b   = {1'b0, acc_q};
        unit_sub = 1'b1;
      end
      // 1000 = 1024 - 16 - 8
      S_K1: begin
        unit_a   = {1'b0, dl_q[53:0], 10'd0};
        unit_b   = {1'b0, dl_q[59:0], 4'd0};
        unit_sub = 1'b1;
      end
      S_K2: begin
        unit_a   = {1'b0, acc_q};
        unit_b   = {1'b0, dl_q[60:0], 3'd0};
        unit_sub = 1'b1;
      end
      S_DIV: begin
        unit_a   = rem_shift;
        unit_b   = {1'b0, di_q};
        unit_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign unit_b_x = unit_sub ? ~unit_b : unit_b;
  assign unit_sum = {1'b0, unit_a} + {1'b0, unit_b_x} + {65'd0, unit_sub};
  assign unit_res = unit_sum[63:0];
  assign unit_ge  = unit_sum[65];

  always_comb begin
    state_d = state_q;
    vcpu_d  = vcpu_q;
    lm_d    = lm_q;
    gm_d    = gm_q;
    ir_d    = ir_q;
    dl_d    = dl_q;
    di_d    = di_q;
    occ_d   = occ_q;
    acc_d   = acc_q;
    opa_d   = opa_q;
    opb_d   = opb_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    dz_d    = dz_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          vcpu_d  = vcpu_i;
          lm_d    = lm_i;
          gm_d    = gm_i;
          ir_d    = ir_i;
          n_d     = line_count_i;
          state_d = S_DL;
        end
      end
      S_DL: begin
        dl_d    = unit_res;
        state_d = S_DG;
      end
      S_DG: begin
        opb_d   = unit_res;
        state_d = S_DI;
      end
      S_DI: begin
        di_d    = unit_res;
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        if (n_q[31:1] != 31'd0) begin
          n_d   = {1'b0, n_q[31:1]};
          opb_d = {1'b0, opb_q[63:1]};
        end else begin
          opa_d   = rd_i.occ;
          acc_d   = 64'd0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (opb_q == 64'd0) begin
          state_d = S_OCC1;
        end else begin
          if (opb_q[0]) begin
            acc_d = unit_res;
          end
          opa_d = {opa_q[62:0], 1'b0};
          opb_d = {1'b0, opb_q[63:1]};
        end
      end
      S_OCC1: begin
        occ_d   = unit_res;
        state_d = S_OCC2;
      end
      S_OCC2: begin
        occ_d   = unit_res;
        state_d = S_K1;
      end
      S_K1: begin
        acc_d   = unit_res;
        state_d = S_K2;
      end
      S_K2: begin
        if (di_q == 64'd0) begin
          dz_d    = 1'b1;
          state_d = S_DONE;
        end else begin
          dz_d    = 1'b0;
          opb_d   = unit_res;
          opa_d   = 64'd0;
          cnt_d   = 6'd0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        opa_d = unit_ge ? unit_res : rem_shift[63:0];
        opb_d = {opb_q[62:0], unit_ge};
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (ack_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vcpu_q <= vcpu_d;
    lm_q   <= lm_d;
    gm_q   <= gm_d;
    ir_q   <= ir_d;
    dl_q   <= dl_d;
    di_q   <= di_d;
    occ_q  <= occ_d;
    acc_q  <= acc_d;
    opa_q  <= opa_d;
    opb_q  <= opb_d;
    n_q    <= n_d;
    cnt_q  <= cnt_d;
    dz_q   <= dz_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign done_o         = (state_q == S_DONE);
  assign occ_we_o       = (state_q == S_OCC2);
  assign occ_wdata_o    = unit_res;
  assign res_o.vcpu      = vcpu_q;
  assign res_o.occupancy = occ_q;
  assign res_o.mpki      = dz_q ? 64'd0 : opb_q;
  assign res_o.dz        = dz_q;

  `VCOA_ASSERT(a_div_nonzero, (state_q == S_DIV) |-> (di_q != 64'd0), "divide with zero divisor")
  `VCOA_ASSERT(a_dz_mpki_zero, (done_o && res_o.dz) |-> (res_o.mpki == 64'd0), "mpki not zero on zero retired delta")
  `VCOA_ASSERT(a_done_hold, (done_o && !ack_i) |=> done_o, "result dropped before handoff")

endmodule

`default_nettype wire

// ===== sv/vcpu_cache_occupancy_accounting_core.sv =====
// Top level of the vcpu cache occupancy accounting core: APB registers,
// request handshake, output register. Depends on vcoa_pkg, vcoa_store, vcoa_engine.
`default_nettype none

// Per-vcpu last-level cache occupancy accounting. A start request (req_type 0)
// snapshots the three counter readings of its vcpu and returns
// nothing. An end request (req_type 1) forms wrapping deltas against those
// snapshots, updates the stored occupancy estimate as
// prev + dlocal - (dglobal >> floor(log2(lines))) * prev and returns it with
// misses per kilo-instruction (dlocal * 1000 / dretired), flagging a zero
// retired delta. Requests are ignored while accounting_enable is 0 or when
// vcpu_index is at or above VCPU_COUNT. All end-request arithmetic runs on one
// shared 65-bit adder under a sequencer, so an end request holds the input
// stalled through the three deltas, the line shift (0 to 31 positions), the
// shift-and-add multiply by the shifted global delta, the occupancy update,
// the scaling by 1000 and the one-bit-per-cycle divide, which is skipped
// when the retired delta is zero, and through any wait for the output
// register to free up. Start and ignored requests do not stall the input. A
// finished result sits in an output register, so a new request is taken
// while it waits. Snapshot and occupancy records clear to zero at reset
// through per-record valid bits; no clearing pass is needed.

module vcpu_cache_occupancy_accounting_core import vcoa_pkg::*; #(
  parameter  int VCPU_COUNT = VCPU_COUNT_DEF,
  localparam int IdxW       = (VCPU_COUNT > 1) ? $clog2(VCPU_COUNT) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [3:0]  vcpu_index_i,
  input  logic [63:0] local_miss_count_i,
  input  logic [63:0] global_miss_count_i,
  input  logic [63:0] retired_count_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  result_vcpu_o,
  output logic [63:0] occupancy_o,
  output logic [63:0] misses_per_kilo_o,
  output logic        divide_by_zero_o
);

  // Configuration registers
  logic        enable_q, enable_d;
  logic [31:0] lines_q, lines_d;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    enable_d = enable_q;
    lines_d  = lines_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_ENABLE: enable_d = pwdata[0];
        REG_LINES:  lines_d  = pwdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      lines_q  <= 32'd0;
    end else begin
      enable_q <= enable_d;
      lines_q  <= lines_d;
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (paddr[2])
      REG_ENABLE: prdata = {31'd0, enable_q};
      REG_LINES:  prdata = lines_q;
      default:    prdata = 32'd0;
    endcase
  end

  // Request decode
  logic            busy;
  logic            in_accept;
  logic            in_range;
  logic            act;
  logic [IdxW-1:0] idx;
  logic [IdxW-1:0] idx_q;
  store_ctl_t      ctl;

  assign in_stall_o = busy;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign in_range   = ({5'd0, vcpu_index_i} < 9'(VCPU_COUNT));
  assign idx        = IdxW'({5'd0, vcpu_index_i});
  // Drop requests while disabled or for a vcpu beyond the record count.
  assign act        = in_accept & enable_q & in_range;

  // Hold the record address for the occupancy write-back.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      idx_q <= idx;
    end
  end

  logic        occ_we;
  logic [63:0] occ_wdata;
  rd_data_t    rd;
  logic        done;
  logic        ack;
  result_t     res;

  assign ctl.rd_en   = act & req_type_i;
  assign ctl.snap_we = act & ~req_type_i;
  assign ctl.occ_we  = occ_we;

  vcoa_store #(
    .VCPU_COUNT(VCPU_COUNT)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .addr_i     (idx),
    .occ_addr_i (idx_q),
    .lcl_i      (local_miss_count_i),
    .glb_i      (global_miss_count_i),
    .ret_i      (retired_count_i),
    .occ_i      (occ_wdata),
    .rd_o       (rd)
  );

  vcoa_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .go_i         (ctl.rd_en),
    .vcpu_i       (vcpu_index_i),
    .lm_i         (local_miss_count_i),
    .gm_i         (global_miss_count_i),
    .ir_i         (retired_count_i),
    .line_count_i (lines_q),
    .rd_i         (rd),
    .ack_i        (ack),
    .busy_o       (busy),
    .done_o       (done),
    .res_o        (res),
    .occ_we_o     (occ_we),
    .occ_wdata_o  (occ_wdata)
  );

  // Output register: take a result when the slot is empty or draining.
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign ack = done & (~out_valid_q | ~out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (ack) begin
      out_valid_d = 1'b1;
    end else if (~out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_vcpu_o     = out_q.vcpu;
  assign occupancy_o       = out_q.occupancy;
  assign misses_per_kilo_o = out_q.mpki;
  assign divide_by_zero_o  = out_q.dz;

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for vcpu_cache_occupancy_accounting_core: queued requests, a
// per-vcpu occupancy predictor and an in-order result scoreboard.
// Depends on vcoa_pkg and the core RTL only.

module testbench import vcoa_pkg::*;;

  // Request kinds carried on req_type.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_END   = 1'b1;

  // Receiver stall behaviors.
  localparam int STALL_NONE   = 0;
  localparam int STALL_COIN   = 1;
  localparam int STALL_LONG   = 2;
  localparam int STALL_SPARSE = 3;

  localparam logic [63:0] ALL_ONES = '1;
  // Longer than the worst end request, with some margin.
  localparam int SETTLE_CYCLES = 250;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int REPORT_LIMIT  = 100;

  typedef struct packed {
    logic        kind;
    logic [3:0]  vcpu;
    logic [63:0] lcl;
    logic [63:0] glb;
    logic [63:0] ret;
  } acct_req_t;

  // Clock, reset and every block input start at known values.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        apb_sel = 1'b0;
  logic        apb_enable = 1'b0;
  logic        apb_write = 1'b0;
  logic [2:0]  apb_addr = '0;
  logic [31:0] apb_wdata = '0;
  logic [31:0] apb_rdata;
  logic        apb_ready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = 1'b0;
  logic [3:0]  vcpu_index = '0;
  logic [63:0] lm_cnt = '0;
  logic [63:0] gm_cnt = '0;
  logic [63:0] retired = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  result_vcpu;
  logic [63:0] occupancy;
  logic [63:0] mpki;
  logic        div_zero;

  vcpu_cache_occupancy_accounting_core uut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .psel                (apb_sel),
    .penable             (apb_enable),
    .pwrite              (apb_write),
    .paddr               (apb_addr),
    .pwdata              (apb_wdata),
    .prdata              (apb_rdata),
    .pready              (apb_ready),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .req_type_i          (req_type),
    .vcpu_index_i        (vcpu_index),
    .local_miss_count_i  (lm_cnt),
    .global_miss_count_i (gm_cnt),
    .retired_count_i     (retired),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .result_vcpu_o       (result_vcpu),
    .occupancy_o         (occupancy),
    .misses_per_kilo_o   (mpki),
    .divide_by_zero_o    (div_zero)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: configuration as last written and one record per vcpu.
  // ---------------------------------------------------------------------------
  logic        acct_on;
  logic [31:0] line_count;
  logic [63:0] snap_lcl [VCPU_COUNT_DEF];
  logic [63:0] snap_glb [VCPU_COUNT_DEF];
  logic [63:0] snap_ret [VCPU_COUNT_DEF];
  logic [63:0] occ_est  [VCPU_COUNT_DEF];

  acct_req_t request_q [$];   // requests still to be driven
  result_t   due_reports [$]; // results the block still owes, oldest first
  int        errors = 0;

  initial begin
    acct_on    = 1'b0;
    line_count = '0;
    for (int i = 0; i < VCPU_COUNT_DEF; i++) begin
      snap_lcl[i] = '0;
      snap_glb[i] = '0;
      snap_ret[i] = '0;
      occ_est[i]  = '0;
    end
  end

  // Shift amount: index of the top set bit, 0 for a count of 0 or 1.
  function automatic int lines_to_shift(logic [31:0] n);
    int s;
    s = 0;
    for (int b = 1; b < 32; b++)
      if (n[b]) s = b;
    return s;
  endfunction

  // Apply one accepted request to the predictor and queue any result it owes.
  task automatic account_request(acct_req_t r);
    logic [63:0] dl, dg, di, prev, scaled;
    result_t     rep;
    if (!acct_on || r.vcpu >= VCPU_COUNT_DEF) return;
    if (r.kind == REQ_START) begin
      snap_lcl[r.vcpu] = r.lcl;
      snap_glb[r.vcpu] = r.glb;
      snap_ret[r.vcpu] = r.ret;
      return;
    end
    dl   = r.lcl - snap_lcl[r.vcpu];
    dg   = r.glb - snap_glb[r.vcpu];
    di   = r.ret - snap_ret[r.vcpu];
    prev = occ_est[r.vcpu];
    occ_est[r.vcpu] = prev + dl - (dg >> lines_to_shift(line_count)) * prev;
    scaled = dl * 64'd1000;
    rep.vcpu      = r.vcpu;
    rep.occupancy = occ_est[r.vcpu];
    rep.mpki      = (di == '0) ? '0 : scaled / di;
    rep.dz        = (di == '0);
    due_reports.push_back(rep);
  endtask

  // ---------------------------------------------------------------------------
  // Handshake sampling. Take both channels at the falling edge, where every
  // signal has settled, and act on it at the next rising edge.
  // ---------------------------------------------------------------------------
  logic    in_taken = 1'b0;
  logic    out_taken = 1'b0;
  result_t out_seen;

  always @(negedge clk) begin
    in_taken  = (in_valid === 1'b1) && (in_stall === 1'b0);
    out_taken = (out_valid === 1'b1) && (out_stall === 1'b0);
    out_seen  = '{vcpu: result_vcpu, occupancy: occupancy, mpki: mpki, dz: div_zero};
  end

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length separated by random gaps. A gap
  // is sometimes long enough to land the next request deep inside the divide.
  // ---------------------------------------------------------------------------
  acct_req_t cur_req;
  int        gap_left;
  int        burst_left;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 7);
    if (r < 3) return 0;
    if (r < 6) return $urandom_range(1, 6);
    if (r == 6) return $urandom_range(7, 40);
    return $urandom_range(41, 180);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      gap_left   = 0;
      burst_left = 1;
    end else begin
      // Feed the predictor with the request the block just took.
      if (in_taken) account_request(cur_req);
      if (in_valid && !in_taken) begin
        // hold: payload stays put until accepted
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        cur_req = request_q.pop_front();
        in_valid    <= 1'b1;
        req_type    <= cur_req.kind;
        vcpu_index  <= cur_req.vcpu;
        lm_cnt      <= cur_req.lcl;
        gm_cnt      <= cur_req.glb;
        retired     <= cur_req.ret;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = pick_gap();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: switch between stall behaviors chosen at random, including
  // spells with no stall at all.
  // ---------------------------------------------------------------------------
  int          stall_mode;
  int          mode_left;
  logic [4:0]  stall_tick;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode = STALL_NONE;
      mode_left  = 0;
      stall_tick = '0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(STALL_NONE, STALL_SPARSE);
        mode_left  = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
        STALL_LONG:  out_stall <= (stall_tick[4:2] != 3'd0);
        default:     out_stall <= ($urandom_range(0, 7) == 0);
      endcase
      stall_tick = stall_tick + 5'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest one owed.
  // ---------------------------------------------------------------------------
  result_t want;

  task automatic check_field(string what, logic [63:0] exp_val, logic [63:0] got_val);
    if (exp_val !== got_val) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_taken) begin
      if (due_reports.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result for vcpu %0d with none expected, expected nothing, actual %h",
                   $time, out_seen.vcpu, out_seen.occupancy);
      end else begin
        want = due_reports.pop_front();
        check_field("result_vcpu", 64'(want.vcpu), 64'(out_seen.vcpu));
        check_field("occupancy", want.occupancy, out_seen.occupancy);
        check_field("misses_per_kilo", want.mpki, out_seen.mpki);
        check_field("divide_by_zero", 64'(want.dz), 64'(out_seen.dz));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_req(logic kind, logic [3:0] vc, logic [63:0] l, logic [63:0] g,
                          logic [63:0] r);
    request_q.push_back('{kind: kind, vcpu: vc, lcl: l, glb: g, ret: r});
  endtask

  // Wait until every request is taken and every owed result has come back,
  // then let the block finish whatever it is still chewing on.
  task automatic drain();
    int n;
    n = 0;
    @(negedge clk);
    while (request_q.size() != 0 || in_valid) @(negedge clk);
    while (due_reports.size() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write one register over APB while the block is idle and track it.
  task automatic write_reg(logic idx, logic [31:0] value);
    drain();
    @(posedge clk);
    apb_sel   <= 1'b1;
    apb_enable <= 1'b0;
    apb_write <= 1'b1;
    apb_addr  <= {idx, 2'b00};
    apb_wdata <= value;
    @(posedge clk);
    apb_enable <= 1'b1;
    @(posedge clk);
    while (apb_ready !== 1'b1) @(posedge clk);
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
    if (idx == REG_ENABLE) acct_on = value[0];
    else line_count = value;
  endtask

  // Counter reading: mostly full random, with the corners mixed in.
  function automatic logic [63:0] pick_count();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return 64'($urandom_range(0, 100000));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Delta between start and end readings, spread over magnitudes so that
  // every shift amount sees both zero and nonzero shifted global deltas.
  function automatic logic [63:0] pick_delta();
    case ($urandom_range(0, 9))
      0:       return '0;
      1, 2:    return 64'($urandom_range(1, 5000));
      3:       return 64'($urandom);
      4:       return {32'($urandom_range(0, 15)), $urandom};
      5:       return ALL_ONES - 64'($urandom_range(0, 5000));
      6:       return 64'd1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly well-formed start/end pairs on random vcpus; the rest is noise:
  // lone ends, repeated starts and arbitrary readings.
  task automatic queue_random(int count);
    int          left;
    logic [3:0]  vc;
    logic [63:0] bl, bg, br;
    left = count;
    while (left > 0) begin
      vc = 4'($urandom_range(0, 15));
      if (left >= 2 && $urandom_range(0, 3) != 0) begin
        bl = pick_count();
        bg = pick_count();
        br = pick_count();
        push_req(REQ_START, vc, bl, bg, br);
        push_req(REQ_END, vc, bl + pick_delta(), bg + pick_delta(), br + pick_delta());
        left -= 2;
      end else begin
        push_req(logic'($urandom_range(0, 1)), vc, pick_count(), pick_count(), pick_count());
        left--;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [31:0] line_settings [6];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Accounting is off out of reset: these requests must leave no trace.
    push_req(REQ_START, 4'd15, ALL_ONES, ALL_ONES, ALL_ONES);
    push_req(REQ_END, 4'd0, 64'd7, 64'd7, 64'd7);
    push_req(REQ_END, 4'd15, '0, '0, '0);

    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_LINES, 32'd0);

    // End without start against cleared snapshots; zero retired delta.
    push_req(REQ_END, 4'd0, '0, '0, '0);
    push_req(REQ_END, 4'd2, 64'd5, '0, 64'd1000);
    // All-ones snapshot, then zeros: every delta wraps to one.
    push_req(REQ_START, 4'd15, ALL_ONES, ALL_ONES, ALL_ONES);
    push_req(REQ_END, 4'd15, '0, '0, '0);
    push_req(REQ_END, 4'd15, '0, '0, '0);
    // Local delta times 1000 overflows 64 bits.
    push_req(REQ_START, 4'd3, '0, '0, '0);
    push_req(REQ_END, 4'd3, ALL_ONES, ALL_ONES, 64'd1);
    // Zero retired delta with a nonzero local delta: occupancy still updates.
    push_req(REQ_START, 4'd4, 64'h1234_5678_9abc_def0, 64'd99, 64'hdead_beef_0000_0001);
    push_req(REQ_END, 4'd4, 64'h1234_5678_9abd_0000, 64'd350, 64'hdead_beef_0000_0001);
    // Local delta of all ones against the cleared snapshot of vcpu 2.
    push_req(REQ_END, 4'd2, ALL_ONES, 64'd3, 64'd999);

    // Disabled again: snapshot of vcpu 15 must survive these.
    write_reg(REG_ENABLE, 32'd0);
    push_req(REQ_START, 4'd15, 64'd1, 64'd2, 64'd3);
    push_req(REQ_END, 4'd15, 64'd4, 64'd5, 64'd6);
    write_reg(REG_ENABLE, 32'd1);
    push_req(REQ_END, 4'd15, '0, '0, '0);

    // Largest shift: only the top of the global delta survives.
    write_reg(REG_LINES, 32'hFFFF_FFFF);
    push_req(REQ_START, 4'd5, '0, '0, '0);
    push_req(REQ_END, 4'd5, 64'd40, ALL_ONES, 64'd4000);
    push_req(REQ_END, 4'd5, 64'd80, 64'h7FFF_FFFF, 64'd8000);

    // Sweep line counts, the extremes among them.
    line_settings[0] = 32'd1;
    line_settings[1] = 32'd2;
    line_settings[2] = $urandom;
    line_settings[3] = 32'hFFFF_FFFF;
    line_settings[4] = 32'd1 << $urandom_range(0, 31);
    line_settings[5] = 32'd0;
    foreach (line_settings[i]) begin
      write_reg(REG_LINES, line_settings[i]);
      queue_random(270);
      if (i == 2) begin
        // Short disabled spell in the middle of the sweep.
        write_reg(REG_ENABLE, 32'd0);
        queue_random(30);
        write_reg(REG_ENABLE, 32'd1);
      end
    end

    drain();
    if (due_reports.size() != 0) begin
      errors += due_reports.size();
      $display("%0t: results never delivered, expected %0d more, actual 0", $time,
               due_reports.size());
    end
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Run limit: far above the slowest correct run.
  initial begin
    #(20_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
